// ===== rtl/psg_pkg.sv =====
// Shared types and constants for the noise / square duty sound channel.
`default_nettype none

package psg_pkg;

  localparam int unsigned TIME_W  = 32;
  localparam int unsigned ACC_W   = 34;
  localparam int unsigned LFSR_W  = 15;
  localparam int unsigned POS_W   = 3;
  localparam int unsigned SMP_W   = 16;
  localparam int unsigned CIDX_W  = 2;

  localparam logic [ACC_W-1:0]  ACC_MAX       = {ACC_W{1'b1}};
  localparam logic [LFSR_W-1:0] LFSR_SEED     = 15'h7FFF;
  localparam logic [LFSR_W-1:0] LFSR_TAP      = 15'h6000;
  localparam logic [SMP_W-1:0]  SAMPLE_HIGH   = 16'h7FFF;
  localparam logic [SMP_W-1:0]  SAMPLE_LOW    = 16'h8001;
  localparam logic [SMP_W-1:0]  SAMPLE_ZERO   = 16'h0000;
  localparam logic [TIME_W-1:0] PERIOD_RESET  = 32'h8000_0000;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_MODE   = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_PERIOD = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_DUTY   = 2'd2;

  // request codes
  localparam logic REQ_ADVANCE = 1'b0;
  localparam logic REQ_RESTART = 1'b1;

  // mode codes
  localparam logic MODE_DUTY  = 1'b0;
  localparam logic MODE_NOISE = 1'b1;

  typedef struct packed {
    logic [ACC_W-1:0]  acc;
    logic [SMP_W-1:0]  sample;
    logic [LFSR_W-1:0] lfsr;
    logic [POS_W-1:0]  pos;
  } gen_state_t;

  typedef struct packed {
    logic              mode;
    logic [TIME_W-1:0] period;
    logic [POS_W-1:0]  duty;
  } gen_cfg_t;

  localparam gen_state_t GEN_RESTART = '{
    acc:    '0,
    sample: SAMPLE_ZERO,
    lfsr:   LFSR_SEED,
    pos:    '0
  };

endpackage

`default_nettype wire

// ===== rtl/psg_noise_and_duty_channel.sv =====
// Top level of the noise / square duty sound channel.
`default_nettype none

// Each accepted item (advance time or restart) yields one held sample in
// the next cycle; one item is taken every cycle unless in_stall is high,
// with the combinational accumulate, saturate, compare and subtract path
// and the generator step between the channel state registers. in_stall
// rises only while a result sits in the output register and out_stall
// holds it. cfg_ready is always high; write configuration only while the
// channel is idle. Samples are +32767, -32767, or 0 after a restart.
module psg_noise_and_duty_channel
  import psg_pkg::*;
(
  input  wire  logic              clk,
  input  wire  logic              rst,
  input  wire  logic              in_valid,
  output logic                    in_stall,
  input  wire  logic              req_type,
  input  wire  logic [TIME_W-1:0] time_step,
  output logic                    out_valid,
  input  wire  logic              out_stall,
  output logic signed [SMP_W-1:0] sample_out,
  input  wire  logic              cfg_valid,
  output logic                    cfg_ready,
  input  wire  logic [CIDX_W-1:0] cfg_index,
  input  wire  logic [TIME_W-1:0] cfg_data
);

  gen_cfg_t   cfg;
  gen_state_t st;
  gen_state_t st_next;
  logic       in_take;
  logic       out_take;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid & out_stall;
  assign in_take   = in_valid & ~in_stall;
  assign out_take  = out_valid & ~out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode   <= MODE_DUTY;
      cfg.period <= PERIOD_RESET;
      cfg.duty   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MODE:   cfg.mode   <= cfg_data[0];
        CFG_PERIOD: cfg.period <= cfg_data;
        CFG_DUTY:   cfg.duty   <= cfg_data[POS_W-1:0];
        default:    ;
      endcase
    end
  end

  psg_gen_step u_step (
    .cur       (st),
    .cfg       (cfg),
    .req_type  (req_type),
    .time_step (time_step),
    .nxt       (st_next)
  );

  // the held sample doubles as the output register: it only moves on an
  // accepted beat, and a beat is accepted only when no result is held or it drains
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= GEN_RESTART;
      out_valid <= 1'b0;
    end else begin
      if (in_take) begin
        st <= st_next;
      end
      if (in_take) begin
        out_valid <= 1'b1;
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign sample_out = st.sample;

  a_restart_zero : assert property (@(posedge clk) disable iff (rst)
    (in_take && req_type == REQ_RESTART) |=> (out_valid && sample_out == SAMPLE_ZERO
      && st.lfsr == LFSR_SEED && st.acc == '0))
    else $error("restart did not clear the channel");

  a_lfsr_live : assert property (@(posedge clk) disable iff (rst)
    st.lfsr != '0)
    else $error("noise register reached the all-zero lockup state");

  a_sample_code : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (sample_out == SAMPLE_ZERO || sample_out == SAMPLE_HIGH
      || sample_out == SAMPLE_LOW))
    else $error("sample outside the channel's output levels");

  a_hold_state : assert property (@(posedge clk) disable iff (rst)
    !in_take |=> $stable(st))
    else $error("channel state moved without an accepted beat");

endmodule

`default_nettype wire

// ===== rtl/psg_gen_step.sv =====
// Next-state logic for one channel item: accumulate, compare, generator step, or restart.
`default_nettype none

module psg_gen_step
  import psg_pkg::*;
(
  input  wire gen_state_t        cur,
  input  wire gen_cfg_t          cfg,
  input  wire logic              req_type,
  input  wire logic [TIME_W-1:0] time_step,
  output gen_state_t             nxt
);

  logic [ACC_W:0]    sum;
  logic [ACC_W-1:0]  sat;
  logic [ACC_W-1:0]  period_ext;
  logic              take;
  logic [LFSR_W-1:0] lfsr_shift;
  logic [LFSR_W-1:0] lfsr_step;
  logic [SMP_W-1:0]  noise_smp;
  logic [POS_W-1:0]  pos_step;
  logic [SMP_W-1:0]  duty_smp;

  always_comb begin
    sum        = {1'b0, cur.acc} + {{(ACC_W + 1 - TIME_W){1'b0}}, time_step};
    // clamp at the top of the accumulator before the compare
    sat        = sum[ACC_W] ? ACC_MAX : sum[ACC_W-1:0];
    period_ext = {{(ACC_W - TIME_W){1'b0}}, cfg.period};
    take       = (sat >= period_ext);

    lfsr_shift = {1'b0, cur.lfsr[LFSR_W-1:1]};
    lfsr_step  = cur.lfsr[0] ? (lfsr_shift ^ LFSR_TAP) : lfsr_shift;
    noise_smp  = cur.lfsr[0] ? SAMPLE_LOW : SAMPLE_HIGH;

    pos_step   = cur.pos + POS_W'(1);
    duty_smp   = (pos_step <= cfg.duty) ? SAMPLE_LOW : SAMPLE_HIGH;

    nxt = cur;
    if (req_type == REQ_RESTART) begin
      nxt = GEN_RESTART;
    end else begin
      nxt.acc = take ? (sat - period_ext) : sat;
      if (take) begin
        if (cfg.mode == MODE_NOISE) begin
          nxt.lfsr   = lfsr_step;
          nxt.sample = noise_smp;
        end else begin
          nxt.pos    = pos_step;
          nxt.sample = duty_smp;
        end
      end
    end
  end

endmodule

`default_nettype wire
